// ===== rtl/integer_to_ascii_hex_dec_core_macros.svh =====
// ----------------------------------------------------------------------------
// integer_to_ascii_hex_dec_core assertion macros
// shared concurrent assertion forms used by the rtl
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_HEX_DEC_CORE_MACROS_SVH
`define INTEGER_TO_ASCII_HEX_DEC_CORE_MACROS_SVH

// same-cycle implication
`define ITOA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ITOA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// types, constants and helpers of the number to text converter
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

    localparam int ValueW   = 64;
    localparam int DecDigits = 20;
    localparam int HexDigits = ValueW / 4;
    localparam int BcdW     = DecDigits * 4;
    localparam int CntW     = $clog2(ValueW);

    localparam logic KIND_HEX = 1'b0;
    localparam logic KIND_DEC = 1'b1;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_X    = 8'h78;
    localparam logic [7:0] CHAR_A    = 8'h61;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PFX0,
        S_PFXX,
        S_HEX,
        S_CONV,
        S_SKIP,
        S_DEC
    } t_state;

    function automatic logic [7:0] glyph(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = CHAR_ZERO + {4'd0, nib};
        end else begin
            ch = CHAR_A + {4'd0, nib} - 8'd10;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_to_ascii_hex_dec_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_hex_dec_core
// renders a 64-bit unsigned value as ascii hex (0x + 16 nibbles) or decimal
// ----------------------------------------------------------------------------
// usage:
//   pulse start with i_kind and i_value while busy is low; the item is taken
//   at that edge and busy stays high until the last character is sent.
//   each character appears on o_character for one cycle with o_valid high;
//   o_last marks the final character of the run. the receiver cannot stall,
//   so characters come at one per cycle once emission begins.
// sequence:
//   hex mode: the prefix 0x, then 16 nibble characters, most significant first.
//   decimal mode: 64 double-dabble shift steps, during which no character is
//   sent, then the 20 bcd digits are shifted out, leading zeros dropped.
//   an item offered in the first cycle with busy low is taken; no new item is
//   taken while busy is high.
// reset:
//   i_rst_n low returns the block to idle and drops o_valid; nothing else is
//   kept between items.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_hex_dec_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    input  wire logic                        i_kind,
    input  wire logic [itoa_pkg::ValueW-1:0] i_value,
    output logic                             busy,
    output logic                             o_valid,
    output logic [7:0]                       o_character,
    output logic                             o_last
);
    import itoa_pkg::*;

    `include "integer_to_ascii_hex_dec_core_macros.svh"

    t_state            r_state, n_state;
    logic [ValueW-1:0] r_bin, n_bin;
    logic [BcdW-1:0]   r_bcd, n_bcd;
    logic [BcdW-1:0]   w_adj;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic              r_valid, n_valid;
    logic [7:0]        r_char, n_char;
    logic              r_last, n_last;
    logic              w_accept;
    logic [3:0]        w_top;

    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && !busy;
    assign o_valid     = r_valid;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign w_top       = r_bcd[BcdW-1 -: 4];

    // add 3 to every bcd digit of 5 or more
    always_comb begin
        for (int d = 0; d < DecDigits; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                w_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                w_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_kind == KIND_DEC) ? S_CONV : S_PFX0;
                end
            end
            S_PFX0: n_state = S_PFXX;
            S_PFXX: n_state = S_HEX;
            S_HEX: begin
                if (r_cnt == '0) begin
                    n_state = S_IDLE;
                end
            end
            S_CONV: begin
                if (r_cnt == '0) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (r_cnt == '0) begin
                    n_state = S_IDLE;
                end else if (w_top != 4'd0) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (r_cnt == '0) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_bin = i_value;
                    n_bcd = '0;
                    n_cnt = (i_kind == KIND_DEC) ? CntW'(ValueW - 1) : CntW'(HexDigits - 1);
                end
            end
            S_PFX0: begin
                n_valid = 1'b1;
                n_char  = CHAR_ZERO;
            end
            S_PFXX: begin
                n_valid = 1'b1;
                n_char  = CHAR_X;
            end
            S_HEX: begin
                n_valid = 1'b1;
                n_char  = glyph(r_bin[ValueW-1 -: 4]);
                n_last  = (r_cnt == '0);
                n_bin   = {r_bin[ValueW-5:0], 4'd0};
                n_cnt   = r_cnt - CntW'(1);
            end
            S_CONV: begin
                n_bcd = {w_adj[BcdW-2:0], r_bin[ValueW-1]};
                n_bin = {r_bin[ValueW-2:0], 1'b0};
                n_cnt = (r_cnt == '0) ? CntW'(DecDigits - 1) : r_cnt - CntW'(1);
            end
            S_SKIP, S_DEC: begin
                n_bcd = {r_bcd[BcdW-5:0], 4'd0};
                n_cnt = r_cnt - CntW'(1);
                if (r_state == S_DEC || w_top != 4'd0 || r_cnt == '0) begin
                    n_valid = 1'b1;
                    n_char  = CHAR_ZERO + {4'd0, w_top};
                    n_last  = (r_cnt == '0);
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_char <= n_char;
    end

    `ITOA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, busy, "accepted item did not raise busy")
    `ITOA_ASSERT_NOW(a_last_idle, i_clk, i_rst_n, o_valid && o_last, !busy, "last character while still busy")
    `ITOA_ASSERT_NOW(a_mid_busy, i_clk, i_rst_n, o_valid && !o_last, busy, "run ended without a last flag")
    `ITOA_ASSERT_NOW(a_conv_quiet, i_clk, i_rst_n, r_state == S_CONV, !o_valid, "character sent during conversion")
    `ITOA_ASSERT_NOW(a_last_valid, i_clk, i_rst_n, o_last, o_valid, "last flag without a character")

endmodule

`default_nettype wire
